FILE: rtl/core/clns_pkg.sv
// shared types, constants and step tables for the character lcd nibble sequencer
package clns_pkg;

    localparam int unsigned CYC_W  = 20;
    localparam int unsigned WAIT_W = 21;
    localparam int unsigned STEP_W = 4;

    // request opcodes
    localparam logic [1:0] OP_INIT   = 2'd0;
    localparam logic [1:0] OP_CMD    = 2'd1;
    localparam logic [1:0] OP_CHAR   = 2'd2;
    localparam logic [1:0] OP_CURSOR = 2'd3;

    // register indexes
    localparam logic [2:0] REG_ENABLE = 3'd0;
    localparam logic [2:0] REG_GAP    = 3'd1;
    localparam logic [2:0] REG_LONG   = 3'd2;
    localparam logic [2:0] REG_PWRUP  = 3'd3;
    localparam logic [2:0] REG_FIRST  = 3'd4;
    localparam logic [2:0] REG_LATER  = 3'd5;

    // register reset values
    localparam logic [CYC_W-1:0] RST_ENABLE = 20'd500;
    localparam logic [CYC_W-1:0] RST_GAP    = 20'd2000;
    localparam logic [CYC_W-1:0] RST_LONG   = 20'd65000;
    localparam logic [CYC_W-1:0] RST_PWRUP  = 20'd200000;
    localparam logic [CYC_W-1:0] RST_FIRST  = 20'd100000;
    localparam logic [CYC_W-1:0] RST_LATER  = 20'd30000;

    // extra wait selection
    localparam logic [1:0] EXTRA_NONE  = 2'd0;
    localparam logic [1:0] EXTRA_FIRST = 2'd1;
    localparam logic [1:0] EXTRA_LATER = 2'd2;
    localparam logic [1:0] EXTRA_LONG  = 2'd3;

    // lcd command bytes and raw nibbles
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_HOME      = 8'h02;
    localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
    localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
    localparam logic [7:0] CMD_ENTRY     = 8'h06;
    localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
    localparam logic [6:0] ROW1_BASE     = 7'h40;
    localparam logic [3:0] RAW_INIT      = 4'h3;
    localparam logic [3:0] RAW_4BIT      = 4'h2;

    localparam logic [STEP_W-1:0] INIT_LAST_STEP = 4'd11;
    localparam logic [STEP_W-1:0] BYTE_LAST_STEP = 4'd1;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data_byte;
        logic [5:0] column;
        logic       row;
    } in_beat_t;

    typedef struct packed {
        logic [CYC_W-1:0]  wait_before;
        logic              reg_select;
        logic [3:0]        nibble;
        logic [CYC_W-1:0]  strobe_cycles;
        logic [WAIT_W-1:0] wait_after;
        logic              last;
    } out_beat_t;

    typedef struct packed {
        logic [CYC_W-1:0] enable_high_cycles;
        logic [CYC_W-1:0] nibble_gap_cycles;
        logic [CYC_W-1:0] long_command_cycles;
        logic [CYC_W-1:0] powerup_cycles;
        logic [CYC_W-1:0] first_init_wait;
        logic [CYC_W-1:0] later_init_wait;
    } cfg_t;

    // classified request held between front and back
    typedef struct packed {
        logic       is_init;
        logic       reg_select;
        logic [7:0] value;
        logic       long_cmd;
    } job_t;

    function automatic logic [3:0] init_nibble(input logic [STEP_W-1:0] step);
        logic [3:0] nib;
        case (step)
            4'd0, 4'd1, 4'd2: nib = RAW_INIT;
            4'd3:             nib = RAW_4BIT;
            4'd4:             nib = CMD_FUNC_SET[7:4];
            4'd5:             nib = CMD_FUNC_SET[3:0];
            4'd6:             nib = CMD_DISP_ON[7:4];
            4'd7:             nib = CMD_DISP_ON[3:0];
            4'd8:             nib = CMD_ENTRY[7:4];
            4'd9:             nib = CMD_ENTRY[3:0];
            4'd10:            nib = CMD_CLEAR[7:4];
            4'd11:            nib = CMD_CLEAR[3:0];
            default:          nib = 4'h0;
        endcase
        return nib;
    endfunction

    function automatic logic [1:0] init_extra(input logic [STEP_W-1:0] step);
        logic [1:0] sel;
        case (step)
            4'd0:        sel = EXTRA_FIRST;
            4'd1, 4'd2:  sel = EXTRA_LATER;
            4'd11:       sel = EXTRA_LONG;
            default:     sel = EXTRA_NONE;
        endcase
        return sel;
    endfunction

endpackage

FILE: rtl/core/char_lcd_nibble_sequencer.sv
// top level of the character lcd nibble sequencer with its register file
// path: taken requests go through the job queue to the back-end output register
// throughput: one result beat per cycle while not stalled, set by the back-end
// step counter; command, character and cursor requests give two beats,
// initialise gives twelve
// a two-entry job queue lets requests be taken while results are stalled
// reset: rst_n async low, clears queue and sequencer, registers to defaults
module char_lcd_nibble_sequencer (
    input  logic                 clk,
    input  logic                 rst_n,
    // request channel
    input  logic                 in_valid,
    input  clns_pkg::in_beat_t   in_data,
    output logic                 in_stall,
    // result channel
    output logic                 out_valid,
    output clns_pkg::out_beat_t  out_data,
    input  logic                 out_stall,
    // register port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    clns_pkg::cfg_t  cfg_reg;
    clns_pkg::cfg_t  cfg_next;
    logic [2:0]      reg_idx;
    logic            reg_wr;
    logic [19:0]     rd_val;

    logic            q_full;
    logic            push;
    clns_pkg::job_t  push_job;
    logic            pop;
    logic            head_valid;
    clns_pkg::job_t  head_job;

    // register file: word-addressed, writes to unused slots dropped
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign reg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (reg_wr)
        begin
            case (reg_idx)
                clns_pkg::REG_ENABLE: cfg_next.enable_high_cycles  = pwdata[19:0];
                clns_pkg::REG_GAP:    cfg_next.nibble_gap_cycles   = pwdata[19:0];
                clns_pkg::REG_LONG:   cfg_next.long_command_cycles = pwdata[19:0];
                clns_pkg::REG_PWRUP:  cfg_next.powerup_cycles      = pwdata[19:0];
                clns_pkg::REG_FIRST:  cfg_next.first_init_wait     = pwdata[19:0];
                clns_pkg::REG_LATER:  cfg_next.later_init_wait     = pwdata[19:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable_high_cycles  <= clns_pkg::RST_ENABLE;
            cfg_reg.nibble_gap_cycles   <= clns_pkg::RST_GAP;
            cfg_reg.long_command_cycles <= clns_pkg::RST_LONG;
            cfg_reg.powerup_cycles      <= clns_pkg::RST_PWRUP;
            cfg_reg.first_init_wait     <= clns_pkg::RST_FIRST;
            cfg_reg.later_init_wait     <= clns_pkg::RST_LATER;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux, unused slots read as zero
    always_comb
    begin
        case (reg_idx)
            clns_pkg::REG_ENABLE: rd_val = cfg_reg.enable_high_cycles;
            clns_pkg::REG_GAP:    rd_val = cfg_reg.nibble_gap_cycles;
            clns_pkg::REG_LONG:   rd_val = cfg_reg.long_command_cycles;
            clns_pkg::REG_PWRUP:  rd_val = cfg_reg.powerup_cycles;
            clns_pkg::REG_FIRST:  rd_val = cfg_reg.first_init_wait;
            clns_pkg::REG_LATER:  rd_val = cfg_reg.later_init_wait;
            default:              rd_val = '0;
        endcase
    end
    assign prdata = {12'd0, rd_val};

    // front end: classify request beats into jobs
    clns_front u_front (
        .in_valid (in_valid),
        .in_data  (in_data),
        .in_stall (in_stall),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    // job queue decouples request acceptance from result stalls
    clns_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // back end: one nibble beat per cycle into the output register when not stalled
    clns_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_data   (out_data),
        .out_stall  (out_stall)
    );

    // a taken request always leaves work queued for the back end
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> head_valid)
        else $error("accepted request not visible in job queue");

    // enable strobe is never reported as zero cycles
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.strobe_cycles != '0))
        else $error("zero strobe time on result beat");

    // only the first initialise nibble carries a power-up wait
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.wait_before != '0) |->
            (out_data.nibble == clns_pkg::RAW_INIT && !out_data.reg_select
             && !out_data.last))
        else $error("power-up wait on a non-initialise beat");

endmodule

FILE: rtl/core/clns_front.sv
// request classifier: turns an input beat into a nibble job for the queue
module clns_front (
    input  logic                in_valid,
    input  clns_pkg::in_beat_t  in_data,
    output logic                in_stall,
    input  logic                q_full,
    output logic                push,
    output clns_pkg::job_t      push_job
);

    logic [6:0] addr;
    logic [7:0] value;
    logic       rs;

    always_comb
    begin
        addr  = (in_data.row ? clns_pkg::ROW1_BASE : 7'h00) + {1'b0, in_data.column};
        value = in_data.data_byte;
        rs    = 1'b0;
        case (in_data.opcode)
            clns_pkg::OP_CHAR:   rs = 1'b1;
            clns_pkg::OP_CURSOR: value = clns_pkg::CMD_SET_DDRAM | {1'b0, addr};
            default:             value = in_data.data_byte;
        endcase
    end

    assign push_job.is_init    = (in_data.opcode == clns_pkg::OP_INIT);
    assign push_job.reg_select = rs;
    assign push_job.value      = value;
    // only instructions get the settle time after clear or home
    assign push_job.long_cmd   = !rs && ((value == clns_pkg::CMD_CLEAR)
                                       || (value == clns_pkg::CMD_HOME));

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

endmodule

FILE: rtl/core/clns_queue.sv
// two-entry job queue between classifier and nibble sequencer
module clns_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  clns_pkg::job_t  push_job,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output clns_pkg::job_t  head_job
);

    clns_pkg::job_t mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_job   = mem[rd_ptr_reg];

endmodule

FILE: rtl/core/clns_back.sv
// nibble sequencer: steps through a job and fills the output register
module clns_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  clns_pkg::cfg_t       cfg,
    input  logic                 head_valid,
    input  clns_pkg::job_t       head_job,
    output logic                 pop,
    output logic                 out_valid,
    output clns_pkg::out_beat_t  out_data,
    input  logic                 out_stall
);

    logic [clns_pkg::STEP_W-1:0] step_reg;
    logic [clns_pkg::STEP_W-1:0] step_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    clns_pkg::out_beat_t         out_reg;
    clns_pkg::out_beat_t         out_next;

    logic                        advance;
    logic                        last_step;
    logic [1:0]                  extra_sel;
    logic [clns_pkg::CYC_W-1:0]  extra;

    assign advance   = head_valid && (!out_valid_reg || !out_stall);
    assign last_step = head_job.is_init ? (step_reg == clns_pkg::INIT_LAST_STEP)
                                        : (step_reg == clns_pkg::BYTE_LAST_STEP);
    assign pop       = advance && last_step;

    always_comb
    begin
        if (head_job.is_init)
        begin
            extra_sel = clns_pkg::init_extra(step_reg);
        end
        else
        begin
            extra_sel = (step_reg[0] && head_job.long_cmd) ? clns_pkg::EXTRA_LONG
                                                           : clns_pkg::EXTRA_NONE;
        end
        case (extra_sel)
            clns_pkg::EXTRA_FIRST: extra = cfg.first_init_wait;
            clns_pkg::EXTRA_LATER: extra = cfg.later_init_wait;
            clns_pkg::EXTRA_LONG:  extra = cfg.long_command_cycles;
            default:               extra = '0;
        endcase

        out_next.wait_before = (head_job.is_init && step_reg == '0) ? cfg.powerup_cycles
                                                                    : '0;
        out_next.reg_select  = head_job.reg_select;
        if (head_job.is_init)
        begin
            out_next.nibble = clns_pkg::init_nibble(step_reg);
        end
        else
        begin
            out_next.nibble = step_reg[0] ? head_job.value[3:0] : head_job.value[7:4];
        end
        out_next.strobe_cycles = (cfg.enable_high_cycles == '0) ? 20'd1
                                                                : cfg.enable_high_cycles;
        out_next.wait_after    = {1'b0, cfg.nibble_gap_cycles} + {1'b0, extra};
        out_next.last          = last_step;

        step_next = step_reg;
        if (advance)
        begin
            step_next = last_step ? '0 : step_reg + 4'd1;
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

FILE: tb/char_lcd_nibble_sequencer_tb.sv
// self-checking testbench for the character lcd nibble sequencer
`timescale 1ns / 1ps

module char_lcd_nibble_sequencer_tb;

    localparam int REG_COUNT      = 6;
    localparam int HOLD_OFF_LEN   = 300;   // long receiver hold-off, in cycles
    localparam int DRAIN_CYCLES   = 8;     // extra wait after the last expected beat is out
    localparam int STUCK_LIMIT    = 2000;  // cycles with no beat before giving up
    localparam int MAX_MSG_LINES  = 100;

    typedef enum int { SET_ZERO, SET_ALL_ONES, SET_RANDOM } reg_setting_t;

    // expected nibble transfers, worked out from the accepted requests and a
    // private copy of the register file
    class nibble_schedule_t;
        logic [clns_pkg::CYC_W-1:0] regs [REG_COUNT];
        clns_pkg::out_beat_t        expected_transfers [$];
        int                         mismatches;

        function new();
            regs[clns_pkg::REG_ENABLE] = clns_pkg::RST_ENABLE;
            regs[clns_pkg::REG_GAP]    = clns_pkg::RST_GAP;
            regs[clns_pkg::REG_LONG]   = clns_pkg::RST_LONG;
            regs[clns_pkg::REG_PWRUP]  = clns_pkg::RST_PWRUP;
            regs[clns_pkg::REG_FIRST]  = clns_pkg::RST_FIRST;
            regs[clns_pkg::REG_LATER]  = clns_pkg::RST_LATER;
            mismatches = 0;
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= MAX_MSG_LINES)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        // writes beyond the last register are dropped
        function void set_register(int idx, logic [31:0] value);
            if (idx < REG_COUNT)
                regs[idx] = value[clns_pkg::CYC_W-1:0];
        endfunction

        task check_register(int idx, logic [31:0] got);
            if (got !== 32'(regs[idx]))
                report($sformatf("register %0d read %h, want %h", idx, got, regs[idx]));
        endtask

        function int pending();
            return expected_transfers.size();
        endfunction

        function void push_transfer(logic [clns_pkg::CYC_W-1:0] pre_wait, logic rs,
                                    logic [3:0] nib, logic [clns_pkg::CYC_W-1:0] extra,
                                    logic is_last);
            clns_pkg::out_beat_t t;
            t.wait_before   = pre_wait;
            t.reg_select    = rs;
            t.nibble        = nib;
            // a zero enable time still gives a one-cycle strobe
            t.strobe_cycles = (regs[clns_pkg::REG_ENABLE] == '0)
                            ? {{(clns_pkg::CYC_W-1){1'b0}}, 1'b1}
                            : regs[clns_pkg::REG_ENABLE];
            t.wait_after    = {1'b0, regs[clns_pkg::REG_GAP]} + {1'b0, extra};
            t.last          = is_last;
            expected_transfers.push_back(t);
        endfunction

        // high nibble then low; only commands clear and home get the long settle
        function void push_byte(logic [7:0] value, logic rs, logic is_cmd, logic is_last);
            logic [clns_pkg::CYC_W-1:0] extra;
            extra = (is_cmd && (value == clns_pkg::CMD_CLEAR || value == clns_pkg::CMD_HOME))
                  ? regs[clns_pkg::REG_LONG] : '0;
            push_transfer('0, rs, value[7:4], '0, 1'b0);
            push_transfer('0, rs, value[3:0], extra, is_last);
        endfunction

        task note_request(clns_pkg::in_beat_t req);
            logic [6:0] base;
            case (req.opcode)
                clns_pkg::OP_INIT:
                begin
                    push_transfer(regs[clns_pkg::REG_PWRUP], 1'b0, clns_pkg::RAW_INIT,
                                  regs[clns_pkg::REG_FIRST], 1'b0);
                    push_transfer('0, 1'b0, clns_pkg::RAW_INIT,
                                  regs[clns_pkg::REG_LATER], 1'b0);
                    push_transfer('0, 1'b0, clns_pkg::RAW_INIT,
                                  regs[clns_pkg::REG_LATER], 1'b0);
                    push_transfer('0, 1'b0, clns_pkg::RAW_4BIT, '0, 1'b0);
                    push_byte(clns_pkg::CMD_FUNC_SET, 1'b0, 1'b1, 1'b0);
                    push_byte(clns_pkg::CMD_DISP_ON, 1'b0, 1'b1, 1'b0);
                    push_byte(clns_pkg::CMD_ENTRY, 1'b0, 1'b1, 1'b0);
                    push_byte(clns_pkg::CMD_CLEAR, 1'b0, 1'b1, 1'b1);
                end
                clns_pkg::OP_CMD:
                    push_byte(req.data_byte, 1'b0, 1'b1, 1'b1);
                clns_pkg::OP_CHAR:
                    push_byte(req.data_byte, 1'b1, 1'b0, 1'b1);
                default:
                begin
                    base = req.row ? clns_pkg::ROW1_BASE : 7'h00;
                    push_byte(clns_pkg::CMD_SET_DDRAM | {1'b0, base + 7'(req.column)},
                              1'b0, 1'b1, 1'b1);
                end
            endcase
        endtask

        task check_transfer(clns_pkg::out_beat_t got);
            clns_pkg::out_beat_t want;
            if (expected_transfers.size() == 0)
            begin
                report($sformatf("result beat with nothing expected: %h", got));
            end
            else
            begin
                want = expected_transfers.pop_front();
                if (got.wait_before !== want.wait_before)
                    report($sformatf("wait_before %h, want %h", got.wait_before, want.wait_before));
                if (got.reg_select !== want.reg_select)
                    report($sformatf("reg_select %b, want %b", got.reg_select, want.reg_select));
                if (got.nibble !== want.nibble)
                    report($sformatf("nibble %h, want %h", got.nibble, want.nibble));
                if (got.strobe_cycles !== want.strobe_cycles)
                    report($sformatf("strobe_cycles %h, want %h",
                                     got.strobe_cycles, want.strobe_cycles));
                if (got.wait_after !== want.wait_after)
                    report($sformatf("wait_after %h, want %h", got.wait_after, want.wait_after));
                if (got.last !== want.last)
                    report($sformatf("last %b, want %b", got.last, want.last));
            end
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    clns_pkg::in_beat_t  in_data;
    logic                in_stall;
    logic                out_valid;
    clns_pkg::out_beat_t out_data;
    logic                out_stall;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [4:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    nibble_schedule_t sched;
    logic             quiet;         // no idling on either side while set
    logic             burst_armed;   // asks the result side for its long hold-off
    int               stuck_cycles;

    char_lcd_nibble_sequencer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .out_stall (out_stall),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // both channels are sampled at the edge, before any driver updates land
    always @(posedge clk)
    begin
        if (rst_n && sched != null)
        begin
            if (in_valid && !in_stall)
                sched.note_request(in_data);
            if (out_valid && !out_stall)
                sched.check_transfer(out_data);
        end
    end

    // watchdog: a run with no beat moving for too long is a hang
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            stuck_cycles <= 0;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles", STUCK_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // result side: random stalls, plus one long hold-off when armed so the
    // job queue fills and the request side backs up
    initial
    begin : result_sink
        bit burst_done;
        burst_done = 1'b0;
        out_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (burst_armed && !burst_done)
            begin
                burst_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_LEN) @(posedge clk);
            end
            out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 6);
        end
    end

    // one request beat, with an occasional bubble in front of it
    task automatic offer_request(clns_pkg::in_beat_t req);
        while (!quiet && $urandom_range(99) < 6)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // builds one request beat from the given fields, unused ones included
    function automatic clns_pkg::in_beat_t make_request(logic [1:0] op, logic [7:0] data,
                                                        logic [5:0] col, logic row);
        clns_pkg::in_beat_t req;
        req.opcode    = op;
        req.data_byte = data;
        req.column    = col;
        req.row       = row;
        return req;
    endfunction

    function automatic clns_pkg::in_beat_t random_request();
        clns_pkg::in_beat_t req;
        int                 pick;
        req.data_byte = 8'($urandom());
        req.column    = 6'($urandom());
        req.row       = 1'($urandom());
        pick = $urandom_range(99);
        // initialise is rare, the three byte-sized requests share the rest
        if (pick < 8)
            req.opcode = clns_pkg::OP_INIT;
        else if (pick < 39)
            req.opcode = clns_pkg::OP_CMD;
        else if (pick < 70)
            req.opcode = clns_pkg::OP_CHAR;
        else
            req.opcode = clns_pkg::OP_CURSOR;
        // clear and home show up often enough to hit the long settle
        if ($urandom_range(7) == 0)
            req.data_byte = $urandom_range(1) ? clns_pkg::CMD_CLEAR : clns_pkg::CMD_HOME;
        return req;
    endfunction

    task automatic run_random(int count);
        repeat (count) offer_request(random_request());
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // registers change only once every expected beat is out
    task automatic wait_drained();
        while (sched.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // setup phase, then access phase, then idle before the next transfer
    task automatic write_register(int idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {3'(idx), 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sched.set_register(idx, value);
        @(posedge clk);
    endtask

    task automatic read_register(int idx);
        logic [31:0] value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {3'(idx), 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        value = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        sched.check_register(idx, value);
        @(posedge clk);
    endtask

    task automatic program_registers(reg_setting_t setting);
        logic [31:0] value;
        for (int i = 0; i < REG_COUNT; i++)
        begin
            case (setting)
                SET_ZERO:     value = '0;
                // upper bits beyond the 20-bit registers must be dropped
                SET_ALL_ONES: value = '1;
                default:
                begin
                    case ($urandom_range(3))
                        0:       value = $urandom_range(15);
                        1:       value = $urandom();
                        2:       value = 32'($urandom_range(20'hFFFFF));
                        default: value = 32'h000F_FFFF;
                    endcase
                end
            endcase
            write_register(i, value);
        end
        // the two addresses past the register file take writes and ignore them
        if (setting == SET_ALL_ONES)
        begin
            write_register(REG_COUNT, $urandom());
            write_register(REG_COUNT + 1, $urandom());
        end
        for (int i = 0; i < REG_COUNT; i++)
            read_register(i);
    endtask

    initial
    begin : main_sequence
        sched       = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        quiet       = 1'b0;
        burst_armed = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values read back, then the directed requests on them
        for (int i = 0; i < REG_COUNT; i++)
            read_register(i);
        offer_request(make_request(clns_pkg::OP_INIT, 8'($urandom()), 6'($urandom()),
                                   1'($urandom())));
        offer_request(make_request(clns_pkg::OP_CMD, 8'h00, 6'($urandom()), 1'b0));
        offer_request(make_request(clns_pkg::OP_CMD, 8'hFF, 6'($urandom()), 1'b1));
        offer_request(make_request(clns_pkg::OP_CMD, clns_pkg::CMD_CLEAR, 6'h3F, 1'b1));
        offer_request(make_request(clns_pkg::OP_CMD, clns_pkg::CMD_HOME, 6'h00, 1'b0));
        offer_request(make_request(clns_pkg::OP_CMD, 8'h03, 6'($urandom()), 1'b0));
        // character bytes equal to clear or home get no long settle
        offer_request(make_request(clns_pkg::OP_CHAR, clns_pkg::CMD_CLEAR, 6'($urandom()),
                                   1'b1));
        offer_request(make_request(clns_pkg::OP_CHAR, clns_pkg::CMD_HOME, 6'($urandom()),
                                   1'b0));
        offer_request(make_request(clns_pkg::OP_CHAR, 8'h00, 6'h3F, 1'b1));
        offer_request(make_request(clns_pkg::OP_CHAR, 8'hFF, 6'h00, 1'b0));
        offer_request(make_request(clns_pkg::OP_CHAR, 8'hA5, 6'($urandom()), 1'b1));
        // cursor corners, including the one that sets every address bit
        offer_request(make_request(clns_pkg::OP_CURSOR, 8'hFF, 6'h00, 1'b0));
        offer_request(make_request(clns_pkg::OP_CURSOR, 8'h00, 6'h3F, 1'b0));
        offer_request(make_request(clns_pkg::OP_CURSOR, clns_pkg::CMD_CLEAR, 6'h00, 1'b1));
        offer_request(make_request(clns_pkg::OP_CURSOR, clns_pkg::CMD_HOME, 6'h3F, 1'b1));
        offer_request(make_request(clns_pkg::OP_CURSOR, 8'($urandom()), 6'h01, 1'b1));
        offer_request(make_request(clns_pkg::OP_INIT, 8'hFF, 6'h3F, 1'b1));
        in_valid <= 1'b0;
        @(posedge clk);
        wait_drained();

        // all registers zero: the enable time shows up as one cycle
        program_registers(SET_ZERO);
        run_random(30);
        wait_drained();

        // all registers at their top value, with no idling on either side
        program_registers(SET_ALL_ONES);
        quiet <= 1'b1;
        run_random(30);
        wait_drained();
        quiet <= 1'b0;

        // long hold-off on the result side while requests keep coming
        program_registers(SET_RANDOM);
        burst_armed <= 1'b1;
        run_random(40);
        wait_drained();

        repeat (4)
        begin
            program_registers(SET_RANDOM);
            run_random(40);
            wait_drained();
        end

        if (sched.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
